@@ hdl/a85_pkg.sv @@
// shared constants and the job record passed from the front end to the back end
// of the base-85 text encoder; no dependencies
`default_nettype none

package a85_pkg;

  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_Z     = 8'h7a;
  localparam logic [7:0] CHAR_TILDE = 8'h7e;
  localparam logic [7:0] CHAR_GT    = 8'h3e;
  localparam logic [7:0] CHAR_NL    = 8'h0a;

  localparam logic [6:0] LINE_LIMIT_RESET = 7'd72;

  // ceil(2^38 / 85): exact quotient for every 32-bit dividend
  localparam logic [31:0] RECIP_85    = 32'd3233857729;
  localparam int          RECIP_SHIFT = 38;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int NUM_DIGITS = 5;

  typedef struct packed {
    logic [31:0] word;       // big-endian group, zero padded for a tail
    logic        grp;        // complete group
    logic        tail;       // partial group at end of data
    logic [1:0]  tail_last;  // index of last tail digit (2..4 digits)
    logic        term;       // terminator follows
  } job_t;

endpackage

`default_nettype wire

@@ hdl/a85_front.sv @@
// front end: takes samples, gathers bytes into groups and makes a job for the back end
// from each completed group or end of data; uses a85_pkg
`default_nettype none

module a85_front import a85_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] sample,
  input  wire logic        end_of_data,
  input  wire logic        queue_full,
  output logic             push,
  output job_t             push_job
);

  logic [23:0] group_bytes;
  logic [1:0]  byte_count;
  logic [7:0]  data_byte;
  logic        accept;

  assign data_byte = sample[15:8];
  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;

  always_comb begin
    push_job           = '0;
    push_job.term      = end_of_data;
    push_job.tail_last = byte_count + 2'd1;
    if (byte_count == 2'd3) begin
      push_job.grp  = 1'b1;
      push_job.word = {group_bytes, data_byte};
    end else begin
      push_job.tail = end_of_data;
      unique case (byte_count)
        2'd0:    push_job.word = {data_byte, 24'd0};
        2'd1:    push_job.word = {group_bytes[7:0], data_byte, 16'd0};
        default: push_job.word = {group_bytes[15:0], data_byte, 8'd0};
      endcase
    end
  end

  // an item that neither completes a group nor ends the data makes no job
  assign push = accept && (byte_count == 2'd3 || end_of_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes <= '0;
      byte_count  <= '0;
    end else if (accept) begin
      if (byte_count == 2'd3 || end_of_data) begin
        group_bytes <= '0;
        byte_count  <= '0;
      end else begin
        group_bytes <= {group_bytes[15:0], data_byte};
        byte_count  <= byte_count + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/a85_queue.sv @@
// short job queue between front and back end, register based; uses a85_pkg
`default_nettype none

module a85_queue import a85_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      full,
  output logic      empty
);

  job_t                entries [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/a85_back.sv @@
// back end: base-85 digit conversion by reciprocal multiply, then a character
// sequencer with line wrap feeding the output register; uses a85_pkg
`default_nettype none

module a85_back import a85_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [6:0] line_limit,
  input  wire logic       queue_empty,
  input  wire job_t       head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      character,
  output logic            last_of_run
);

  localparam logic [2:0] PH_GRP  = 3'd0;
  localparam logic [2:0] PH_NL   = 3'd1;
  localparam logic [2:0] PH_TAIL = 3'd2;
  localparam logic [2:0] PH_T1   = 3'd3;
  localparam logic [2:0] PH_T2   = 3'd4;
  localparam logic [2:0] PH_T3   = 3'd5;

  // ---------------- converter ----------------
  logic        cbusy;
  logic        cdone;
  logic [2:0]  cnt;
  logic [31:0] x;
  logic [31:0] px;
  logic [6:0]  cdig [0:NUM_DIGITS-1];
  job_t        cjob;
  logic        czero;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [13:0] x85;
  logic [6:0]  dig_new;
  logic        handoff;
  logic        ebusy;

  assign prod    = {32'd0, x} * {32'd0, RECIP_85};
  assign quot    = {6'd0, prod[63:RECIP_SHIFT]};
  // the remainder is below 85, so its low seven bits are enough
  assign x85     = {7'd0, x[6:0]} * 14'd85;
  assign dig_new = px[6:0] - x85[6:0];

  assign handoff = cdone && !ebusy;
  assign pop     = !queue_empty && ((!cbusy && !cdone) || handoff);

  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      cdone <= 1'b0;
      cnt   <= '0;
    end else if (pop) begin
      cbusy <= 1'b1;
      cdone <= 1'b0;
      cnt   <= '0;
    end else if (cbusy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd5) begin
        cbusy <= 1'b0;
        cdone <= 1'b1;
      end
    end else if (handoff) begin
      cdone <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x     <= head_job.word;
      cjob  <= head_job;
      czero <= (head_job.word == 32'd0);
    end else if (cbusy) begin
      px <= x;
      if (cnt != 3'd5) begin
        x <= quot;
      end
      // digits come out least significant first
      if (cnt != 3'd0) begin
        cdig[3'(NUM_DIGITS) - cnt] <= dig_new;
      end
    end
  end

  // ---------------- character sequencer ----------------
  logic [6:0] edig [0:NUM_DIGITS-1];
  logic       ezero;
  logic       eterm;
  logic [1:0] etail_last;
  logic [2:0] phase;
  logic [2:0] idx;
  logic [7:0] column;

  logic [2:0] phase_next;
  logic [2:0] idx_next;
  logic [7:0] column_next;
  logic [7:0] col_sum;
  logic [7:0] ch;
  logic [7:0] dig_char;
  logic       finish;
  logic       emit;

  assign emit     = ebusy && (!out_valid || !out_stall);
  assign dig_char = {1'b0, edig[idx]} + CHAR_BANG;
  assign col_sum  = column + (ezero ? 8'd1 : 8'd5);

  always_comb begin
    phase_next  = phase;
    idx_next    = idx + 3'd1;
    column_next = column;
    ch          = dig_char;
    finish      = 1'b0;
    unique case (phase)
      PH_GRP: begin
        if (ezero || idx == 3'(NUM_DIGITS - 1)) begin
          if (ezero) begin
            ch = CHAR_Z;
          end
          column_next = col_sum;
          idx_next    = '0;
          priority if (col_sum > {1'b0, line_limit}) begin
            phase_next = PH_NL;
          end else if (eterm) begin
            phase_next = PH_T1;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_NL: begin
        ch          = CHAR_NL;
        column_next = '0;
        if (eterm) begin
          phase_next = PH_T1;
        end else begin
          finish = 1'b1;
        end
      end
      PH_TAIL: begin
        if (idx == {1'b0, etail_last}) begin
          phase_next = PH_T1;
        end
      end
      PH_T1: begin
        ch         = CHAR_TILDE;
        phase_next = PH_T2;
      end
      PH_T2: begin
        ch         = CHAR_GT;
        phase_next = PH_T3;
      end
      PH_T3: begin
        ch          = CHAR_NL;
        column_next = '0;
        finish      = 1'b1;
      end
      default: begin
        ch     = CHAR_NL;
        finish = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ebusy  <= 1'b0;
      phase  <= PH_GRP;
      idx    <= '0;
      column <= '0;
    end else if (handoff) begin
      ebusy <= 1'b1;
      idx   <= '0;
      priority if (cjob.grp) begin
        phase <= PH_GRP;
      end else if (cjob.tail) begin
        phase <= PH_TAIL;
      end else begin
        phase <= PH_T1;
      end
    end else if (emit) begin
      phase  <= phase_next;
      idx    <= idx_next;
      column <= column_next;
      if (finish) begin
        ebusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      edig       <= cdig;
      ezero      <= czero && cjob.grp;
      eterm      <= cjob.term;
      etail_last <= cjob.tail_last;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character   <= ch;
      last_of_run <= finish;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ascii85_stream_encoder_core.sv @@
// top level of the base-85 text encoder: line limit register, front end,
// job queue and back end; uses a85_pkg, a85_front, a85_queue, a85_back
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    sample[15:0], end_of_data
//   out      output     out_valid/out_stall  character[7:0], last_of_run
//   cfg      input      cfg_write            cfg_data[6:0] (line limit)
//
// an item is taken every cycle until the 4-entry job queue fills; in the back end
// the six-step reciprocal multiply digit loop converts the next job while the
// sequencer sends the characters of the last, one per cycle unless out_stall holds
// them, up to 6 for a job that does not end the data; a job that ends the data sends
// up to 9 characters, and the next handoff waits until the last of them is sent
// rst is synchronous and clears queue, group and column; line limit resets to 72
// out_stall holds the output register, in_stall is high only while the queue is full
`default_nettype none

module ascii85_stream_encoder_core import a85_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] sample,
  input  wire logic        end_of_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       character,
  output logic             last_of_run,
  input  wire logic        cfg_write,
  input  wire logic [6:0]  cfg_data
);

  logic [6:0] line_limit;
  logic       queue_full;
  logic       queue_empty;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LINE_LIMIT_RESET;
    end else if (cfg_write) begin
      line_limit <= cfg_data;
    end
  end

  a85_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .end_of_data (end_of_data),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  a85_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  a85_back u_back (
    .clk         (clk),
    .rst         (rst),
    .line_limit  (line_limit),
    .queue_empty (queue_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .character   (character),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

@@ dv/tb_ascii85_stream_encoder_core.sv @@
// self-checking testbench for ascii85_stream_encoder_core: a text predictor class
// tracks group, byte count, column and line limit and checks every output character
// depends on a85_pkg and the encoder rtl
`default_nettype none

module tb_ascii85_stream_encoder_core;
  import a85_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_SPARSE, FILL_ONES} fill_kind_t;

  class a85_text_check;
    logic [6:0]  line_limit;
    logic [23:0] group_bytes;
    logic [1:0]  byte_count;
    logic [7:0]  line_column;
    text_char_t  expected_text[$];
    int          mismatches;

    function new();
      line_limit  = LINE_LIMIT_RESET;
      group_bytes = '0;
      byte_count  = '0;
      line_column = '0;
      mismatches  = 0;
    endfunction

    // base-85 digits of word, most significant first, only the first count of them
    function automatic void add_digits(ref text_char_t run[$], input logic [31:0] word,
                                       input int count);
      logic [7:0]  digit[5];
      logic [31:0] rest;
      text_char_t  c;
      rest = word;
      for (int i = 4; i >= 0; i--) begin
        digit[i] = 8'(rest % 32'd85) + CHAR_BANG;
        rest = rest / 32'd85;
      end
      for (int i = 0; i < count; i++) begin
        c.ch = digit[i];
        c.last = 1'b0;
        run.push_back(c);
      end
    endfunction

    function automatic void add_char(ref text_char_t run[$], input logic [7:0] ch);
      text_char_t c;
      c.ch = ch;
      c.last = 1'b0;
      run.push_back(c);
    endfunction

    function automatic void note_input(logic [15:0] sample, logic end_of_data);
      text_char_t  run[$];
      logic [7:0]  data_byte;
      logic [31:0] word;
      data_byte = sample[15:8];
      if (byte_count == 2'd3) begin
        word = {group_bytes, data_byte};
        if (word == '0) begin
          add_char(run, CHAR_Z);
          line_column = line_column + 8'd1;
        end else begin
          add_digits(run, word, 5);
          line_column = line_column + 8'd5;
        end
        if (line_column > {1'b0, line_limit}) begin
          add_char(run, CHAR_NL);
          line_column = '0;
        end
        group_bytes = '0;
        byte_count = '0;
      end else begin
        group_bytes = {group_bytes[15:0], data_byte};
        byte_count = byte_count + 2'd1;
      end
      if (end_of_data) begin
        if (byte_count != 2'd0) begin
          // tail is zero padded, no 'z' shortcut and no line check
          word = {8'h00, group_bytes} << (8 * (4 - int'(byte_count)));
          add_digits(run, word, int'(byte_count) + 1);
        end
        add_char(run, CHAR_TILDE);
        add_char(run, CHAR_GT);
        add_char(run, CHAR_NL);
        group_bytes = '0;
        byte_count = '0;
        line_column = '0;
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_text.push_back(run[i]);
    endfunction

    function automatic void check_result(logic [7:0] ch, logic last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $error("character: expected none, got %h", ch);
        mismatches++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        $error("character: expected %h, got %h", want.ch, ch);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] sample;
  logic        end_of_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  character;
  logic        last_of_run;
  logic        cfg_write;
  logic [6:0]  cfg_data;

  a85_text_check text_check = new();
  bit steady = 1'b0;

  ascii85_stream_encoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .end_of_data(end_of_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last_of_run(last_of_run),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 16);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) text_check.check_result(character, last_of_run);
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [15:0] s, logic e);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    end_of_data <= e;
    do @(posedge clk); while (in_stall);
    text_check.note_input(s, e);
    @(negedge clk);
  endtask

  // wait for all text to leave, then for any group still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (text_check.expected_text.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic set_limit(logic [6:0] limit);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= limit;
    @(negedge clk);
    cfg_write <= 1'b0;
    text_check.line_limit = limit;
  endtask

  function automatic logic [7:0] pick_byte(fill_kind_t kind);
    case (kind)
      FILL_ZERO:   pick_byte = 8'h00;
      FILL_SPARSE: pick_byte = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
      FILL_ONES:   pick_byte = 8'hff;
      default:     pick_byte = 8'($urandom);
    endcase
  endfunction

  // one data stream ending in end of data; a few streams are left open
  task automatic send_stream(int len, fill_kind_t kind, bit open_end);
    for (int i = 0; i < len; i++) begin
      send_item({pick_byte(kind), 8'($urandom)}, (i == len - 1) && !open_end);
    end
  endtask

  task automatic random_phase(int budget);
    int left;
    int len;
    left = budget;
    while (left > 0) begin
      len = $urandom_range(1, 14);
      if (len > left) len = left;
      send_stream(len, fill_kind_t'($urandom_range(3)), $urandom_range(7) == 0);
      left -= len;
    end
  endtask

  task automatic directed_phase();
    // bit 16 marks end of data
    logic [16:0] items[22] = '{
      17'h000ff, 17'h00000, 17'h00012, 17'h00080,   // zero group
      17'h0ffff, 17'h0ff00, 17'h0ff55, 17'h0ffaa,   // all ones group
      17'h1007f,                                    // one-byte zero tail
      17'h0ab01, 17'h1cd02,                         // two-byte tail
      17'h00000, 17'h00000, 17'h10000,              // three-byte zero tail
      17'h00100, 17'h0020f, 17'h003f0, 17'h104ff,   // full group at end
      17'h000ff, 17'h00000, 17'h00000, 17'h10001    // zero group at end
    };
    foreach (items[i]) send_item(items[i][15:0], items[i][16]);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample <= '0;
    end_of_data <= 1'b0;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_limit(7'd1);
    directed_phase();

    // long unbroken line to pass the widest limit, with no idling on either side
    set_limit(7'd127);
    steady = 1'b1;
    send_stream(112, FILL_RANDOM, 1'b0);
    steady = 1'b0;

    set_limit(7'd0);
    random_phase(19);
    set_limit(LINE_LIMIT_RESET);
    random_phase(19);
    set_limit(7'($urandom_range(1, 127)));
    random_phase(19);
    set_limit(7'd2);
    random_phase(19);

    drain();
    if (text_check.mismatches == 0 && text_check.expected_text.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
